### rtl/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, ignored while reset is high
`define CHK_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("ihex port check failed");

// clocked property that also holds across reset
`define CHK_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("ihex reset check failed");

`endif

### rtl/ihex_pkg.sv
`default_nettype none

package ihex_pkg;

  localparam int QueueDepth = 2;

  localparam logic [31:0] MEM_LIMIT_RESET = 32'hFFFF_FFFF;

  localparam logic [2:0] KIND_WRITE    = 3'd0;
  localparam logic [2:0] KIND_END      = 3'd1;
  localparam logic [2:0] KIND_BADSTART = 3'd2;
  localparam logic [2:0] KIND_BADTYPE  = 3'd3;
  localparam logic [2:0] KIND_BADHEX   = 3'd4;

  localparam logic [7:0] TYPE_DATA  = 8'h00;
  localparam logic [7:0] TYPE_EOF   = 8'h01;
  localparam logic [7:0] TYPE_EXT   = 8'h04;
  localparam logic [7:0] CHAR_COLON = 8'h3A;

  // one classified non-whitespace character
  typedef struct packed {
    logic       colon;
    logic       hex;
    logic [3:0] nibble;
  } token_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] address;
    logic [7:0]  data_byte;
    logic        over_limit;
  } result_t;

endpackage

`default_nettype wire

### rtl/ihex_fifo.sv
`default_nettype none

module ihex_fifo import ihex_pkg::*; #(
  parameter int Width = 8,
  parameter int Depth = QueueDepth
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [Width-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic      [Width-1:0] rdata,
  output logic                  empty
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] entries [Depth];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [CntW-1:0]  count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CntW'(Depth));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= wdata;
    end
  end

endmodule

`default_nettype wire

### rtl/ihex_front.sv
`default_nettype none

module ihex_front import ihex_pkg::*; #(
  parameter int Depth = QueueDepth
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  input  wire logic [7:0] char_code,
  output logic            full,
  output logic            tok_valid,
  output token_t          tok,
  input  wire logic       tok_pop
);

  logic   is_space;
  logic   tok_empty;
  token_t tok_in;

  // space, tab, lf, vt, ff, cr are dropped here
  always_comb begin
    is_space = (char_code == 8'h20) || (char_code >= 8'h09 && char_code <= 8'h0D);
    tok_in   = '0;
    if (char_code == CHAR_COLON) begin
      tok_in.colon = 1'b1;
    end else if (char_code >= 8'h30 && char_code <= 8'h39) begin
      tok_in.hex    = 1'b1;
      tok_in.nibble = char_code[3:0];
    end else if ((char_code >= 8'h41 && char_code <= 8'h46) ||
                 (char_code >= 8'h61 && char_code <= 8'h66)) begin
      tok_in.hex    = 1'b1;
      tok_in.nibble = char_code[3:0] + 4'd9;
    end
  end

  ihex_fifo #(
    .Width($bits(token_t)),
    .Depth(Depth)
  ) u_tok_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push && !is_space),
    .wdata (tok_in),
    .full  (full),
    .pop   (tok_pop),
    .rdata (tok),
    .empty (tok_empty)
  );

  assign tok_valid = !tok_empty;

endmodule

`default_nettype wire

### rtl/ihex_back.sv
`default_nettype none

module ihex_back import ihex_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [31:0] mem_limit,
  input  wire logic        tok_valid,
  input  wire token_t      tok,
  output logic             tok_pop,
  input  wire logic        res_full,
  output logic             res_push,
  output result_t          res
);

  localparam logic [2:0] PH_START = 3'd0;
  localparam logic [2:0] PH_LEN   = 3'd1;
  localparam logic [2:0] PH_ADH   = 3'd2;
  localparam logic [2:0] PH_ADL   = 3'd3;
  localparam logic [2:0] PH_TYPE  = 3'd4;
  localparam logic [2:0] PH_DATA  = 3'd5;
  localparam logic [2:0] PH_EXT   = 3'd6;
  localparam logic [2:0] PH_CHK   = 3'd7;

  logic [2:0]  phase, phase_next;
  logic        nibble_count, nibble_count_next;
  logic [3:0]  high_nibble, high_nibble_next;
  logic [7:0]  record_length, record_length_next;
  logic [15:0] record_address, record_address_next;
  logic [15:0] upper_address, upper_address_next;
  logic [7:0]  byte_index, byte_index_next;
  logic [31:0] write_address, write_address_next;
  logic        stopped, stopped_next;
  logic        take;
  logic [7:0]  byte_val;
  logic [7:0]  index_inc;

  assign take     = tok_valid && !res_full;
  assign tok_pop  = take;
  assign byte_val = {high_nibble, tok.nibble};
  assign index_inc = byte_index + 8'd1;

  always_comb begin
    phase_next          = phase;
    nibble_count_next   = nibble_count;
    high_nibble_next    = high_nibble;
    record_length_next  = record_length;
    record_address_next = record_address;
    upper_address_next  = upper_address;
    byte_index_next     = byte_index;
    write_address_next  = write_address;
    stopped_next        = stopped;
    res_push            = 1'b0;
    res                 = '0;

    if (take && !stopped) begin
      if (phase == PH_START) begin
        if (tok.colon) begin
          phase_next        = PH_LEN;
          nibble_count_next = 1'b0;
        end else begin
          stopped_next = 1'b1;
          res_push     = 1'b1;
          res.kind     = KIND_BADSTART;
        end
      end else if (!tok.hex) begin
        stopped_next = 1'b1;
        res_push     = 1'b1;
        res.kind     = KIND_BADHEX;
      end else if (!nibble_count) begin
        high_nibble_next  = tok.nibble;
        nibble_count_next = 1'b1;
      end else begin
        nibble_count_next = 1'b0;
        case (phase)
          PH_LEN: begin
            record_length_next = byte_val;
            phase_next         = PH_ADH;
          end
          PH_ADH: begin
            record_address_next = {byte_val, 8'h00};
            phase_next          = PH_ADL;
          end
          PH_ADL: begin
            record_address_next[7:0] = byte_val;
            phase_next               = PH_TYPE;
          end
          PH_TYPE: begin
            byte_index_next = '0;
            if (byte_val == TYPE_DATA) begin
              write_address_next = {upper_address, record_address};
              phase_next = (record_length != '0) ? PH_DATA : PH_CHK;
            end else if (byte_val == TYPE_EXT) begin
              phase_next = PH_EXT;
            end else begin
              stopped_next = 1'b1;
              res_push     = 1'b1;
              if (byte_val == TYPE_EOF) begin
                res.kind    = KIND_END;
                res.address = write_address;
              end else begin
                res.kind = KIND_BADTYPE;
              end
            end
          end
          PH_DATA: begin
            res_push           = 1'b1;
            res.kind           = KIND_WRITE;
            res.address        = write_address;
            res.data_byte      = byte_val;
            res.over_limit     = (write_address > mem_limit);
            write_address_next = write_address + 32'd1;
            byte_index_next    = index_inc;
            if (index_inc >= record_length) begin
              phase_next = PH_CHK;
            end
          end
          PH_EXT: begin
            if (byte_index == '0) begin
              upper_address_next = {byte_val, 8'h00};
              byte_index_next    = 8'd1;
            end else begin
              upper_address_next[7:0] = byte_val;
              byte_index_next         = '0;
              phase_next              = PH_CHK;
            end
          end
          default: begin
            phase_next = PH_START;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_START;
      nibble_count   <= 1'b0;
      high_nibble    <= '0;
      record_length  <= '0;
      record_address <= '0;
      upper_address  <= '0;
      byte_index     <= '0;
      write_address  <= '0;
      stopped        <= 1'b0;
    end else begin
      phase          <= phase_next;
      nibble_count   <= nibble_count_next;
      high_nibble    <= high_nibble_next;
      record_length  <= record_length_next;
      record_address <= record_address_next;
      upper_address  <= upper_address_next;
      byte_index     <= byte_index_next;
      write_address  <= write_address_next;
      stopped        <= stopped_next;
    end
  end

endmodule

`default_nettype wire

### rtl/intel_hex_record_parser.sv
// intel hex record parser
// input channel: one ascii character per transfer on char_code, taken at a
//   clock edge with push high and full low; whitespace is dropped on entry
// result channel: while empty is low the oldest result sits on kind, address,
//   data_byte and over_limit; it is taken at an edge with pop high
// config channel: cfg_data is written into mem_limit when cfg_valid is high;
//   cfg_ready is always high, write only while the parser is idle
// rate: one character per cycle while the result queue is not full, set by the
//   record state machine in the back end
// path: the character is queued in the token queue at its transfer edge, the
//   state machine reads it from the queue head and its result is registered
//   into the result queue, where it clears empty
// stall: when pop is held low the result queue fills, the back end stops
//   taking characters, the character queue fills and full rises; nothing is
//   lost or dropped
// reset: queues empty, parser waits for a colon, upper address and end
//   address zero, mem_limit all ones; after an end or error result all
//   further characters are taken and ignored until reset
`default_nettype none

module intel_hex_record_parser import ihex_pkg::*; #(
  parameter int QUEUE_DEPTH = QueueDepth
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // character input
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  char_code,
  // result output
  output logic             empty,
  input  wire logic        pop,
  output logic      [2:0]  kind,
  output logic      [31:0] address,
  output logic      [7:0]  data_byte,
  output logic             over_limit,
  // mem_limit write channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_data
);

  logic [31:0] mem_limit;
  logic        tok_valid;
  token_t      tok;
  logic        tok_pop;
  logic        res_full;
  logic        res_push;
  result_t     res;
  result_t     res_head;

  // config register, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mem_limit <= MEM_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      mem_limit <= cfg_data;
    end
  end

  // front: classify characters into tokens and queue them
  ihex_front #(
    .Depth(QUEUE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .char_code (char_code),
    .full      (full),
    .tok_valid (tok_valid),
    .tok       (tok),
    .tok_pop   (tok_pop)
  );

  // back: record state machine, one token per cycle when results can drain
  ihex_back u_back (
    .clk       (clk),
    .rst       (rst),
    .mem_limit (mem_limit),
    .tok_valid (tok_valid),
    .tok       (tok),
    .tok_pop   (tok_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res)
  );

  // result queue decouples the receiver from the state machine
  ihex_fifo #(
    .Width($bits(result_t)),
    .Depth(QUEUE_DEPTH)
  ) u_res_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_head),
    .empty (empty)
  );

  assign kind       = res_head.kind;
  assign address    = res_head.address;
  assign data_byte  = res_head.data_byte;
  assign over_limit = res_head.over_limit;

endmodule

`default_nettype wire

### rtl/ihex_checker.sv
`default_nettype none
`include "assert_macros.svh"

module ihex_checker import ihex_pkg::*; (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        full,
  input wire logic        empty,
  input wire logic        pop,
  input wire logic [2:0]  kind,
  input wire logic [31:0] address,
  input wire logic [7:0]  data_byte,
  input wire logic        over_limit
);

  logic        final_seen;
  logic        head_is_write;
  logic        head_has_addr;
  logic        head_clean;
  logic [43:0] head_word;

  assign head_is_write = (kind == KIND_WRITE);
  assign head_has_addr = (kind == KIND_WRITE) || (kind == KIND_END);
  assign head_clean    = !over_limit && (data_byte == 8'h00) &&
                         (head_has_addr || (address == 32'h0));
  assign head_word     = {kind, address, data_byte, over_limit};

  // set once an end or error result has been transferred
  always_ff @(posedge clk) begin
    if (rst) begin
      final_seen <= 1'b0;
    end else if (pop && !empty && !head_is_write) begin
      final_seen <= 1'b1;
    end
  end

  `CHK_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> (empty && !full))

  `CHK_ASSERT(a_nothing_after_final, clk, rst, final_seen |-> empty)

  `CHK_ASSERT(a_nonwrite_clean, clk, rst, (!empty && !head_is_write) |-> head_clean)

  `CHK_ASSERT(a_head_holds, clk, rst, (!empty && !pop) |=> (!empty && $stable(head_word)))

endmodule

bind intel_hex_record_parser ihex_checker u_ihex_checker (.*);

`default_nettype wire
